@@ rtl/tbb_pkg.sv @@
package tbb_pkg;

	localparam int FRAC_BITS = 16;
	localparam int WORD_W = 32;
	localparam int ACC_W = 64;

	typedef logic signed [WORD_W-1:0] word_t;
	typedef logic signed [ACC_W-1:0] acc_t;

	// 1.0 in fixed point, used to pass the translation column through the multiplier
	localparam word_t FX_ONE = word_t'(64'sd1 <<< FRAC_BITS);
	localparam acc_t FX_HALF = acc_t'(64'sd1 <<< (FRAC_BITS - 1));
	localparam word_t WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
	localparam word_t WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

	typedef enum logic [1:0] {
		OP_VIEW_ROW  = 2'd0,
		OP_MODEL_ROW = 2'd1,
		OP_BOX       = 2'd2,
		OP_CLEAR     = 2'd3
	} opcode_t;

	typedef struct packed {
		logic       corner;
		logic [3:0] idx;
	} tag_t;

	typedef struct packed {
		logic  valid;
		logic  first;
		logic  last;
		tag_t  tag;
		word_t a;
		word_t b;
	} mac_req_t;

	typedef struct packed {
		logic  valid;
		tag_t  tag;
		word_t value;
	} mac_rsp_t;

endpackage

@@ rtl/tbb_mac.sv @@
module tbb_mac (
	input  logic              clk,
	input  logic              arst_n,
	input  tbb_pkg::mac_req_t req,
	output tbb_pkg::mac_rsp_t rsp
);
	import tbb_pkg::*;

	acc_t  prod_s1;
	logic  valid_s1;
	logic  first_s1;
	logic  last_s1;
	tag_t  tag_s1;
	acc_t  acc_q;
	logic  rsp_valid_q;
	tag_t  rsp_tag_q;
	word_t rsp_value_q;
	acc_t  rnd;
	acc_t  sum;
	word_t sat;

	// round half up, then add into the running dot product
	always_comb begin
		rnd = (prod_s1 + FX_HALF) >>> FRAC_BITS;
		sum = (first_s1 ? '0 : acc_q) + rnd;
		if (sum > acc_t'(WORD_MAX))
			sat = WORD_MAX;
		else if (sum < acc_t'(WORD_MIN))
			sat = WORD_MIN;
		else
			sat = sum[WORD_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			first_s1 <= 1'b0;
			last_s1 <= 1'b0;
			tag_s1 <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			valid_s1 <= req.valid;
			first_s1 <= req.first;
			last_s1 <= req.last;
			tag_s1 <= req.tag;
			rsp_valid_q <= valid_s1 && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= acc_t'(req.a) * acc_t'(req.b);
		if (valid_s1) begin
			acc_q <= sum;
			rsp_value_q <= sat;
			rsp_tag_q <= tag_s1;
		end
	end

	assign rsp = {rsp_valid_q, rsp_tag_q, rsp_value_q};

endmodule

@@ rtl/transformed_box_bounds.sv @@
// transformed box bounds: running view-space box over transformed model boxes
//
// input channel s_*: one transfer per command. s_tuser carries the opcode
// (view row load, model row load, box accumulate, clear bounds); s_tdata
// carries the row index and six Q16.16 values. row loads give no result.
// output channel m_*: one transfer per box or clear command, holding the
// six running bounds.
//
// a box runs through one shared 32x32 multiplier with a two-stage
// multiply/round-accumulate pipe: 48 products form view*model (rows 0-2),
// then 96 products transform the eight corners (translation passed in as a
// product with 1.0). each phase is followed by a drain state, then the
// output state loads the result, and no new command is taken before
// that. a row load leaves the sequencer idle, a clear goes straight to
// the output state. s_tready is high only while the sequencer is idle.
// reset clears both matrices to zero and sets the bounds to empty (min at
// the most positive value, max at the most negative value).
// a stalled receiver holds the result in the output register; the block
// keeps taking commands and waits, not ready, only when a new result is due.
module transformed_box_bounds (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// row_index[1:0], val_a, val_b, val_c, val_d, val_e, val_f, zero pad
	input  logic [199:0] s_tdata,
	// opcode[1:0]
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// bound_min_x, bound_min_y, bound_min_z, bound_max_x, bound_max_y, bound_max_z
	output logic [191:0] m_tdata
);
	import tbb_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MV,
		ST_MV_DRAIN,
		ST_CORNER,
		ST_CN_DRAIN,
		ST_OUT
	} state_t;

	state_t   state_q;
	word_t    view_q [12];
	word_t    model_q [16];
	word_t    mv_q [12];
	word_t    lo_q [3];
	word_t    hi_q [3];
	word_t    low_q [3];
	word_t    high_q [3];
	logic [1:0] k_q;
	logic [1:0] r_q;
	logic [2:0] j_q;
	logic       drain_q;
	logic       m_tvalid_q;
	logic [191:0] m_tdata_q;

	mac_req_t req;
	mac_rsp_t rsp;
	opcode_t  op;
	logic [1:0] row;
	word_t    vals [6];
	word_t    corner_pt;
	logic     accept;

	assign op = opcode_t'(s_tuser);
	assign row = s_tdata[1:0];
	always_comb begin
		for (int i = 0; i < 6; i++)
			vals[i] = s_tdata[2 + 32*i +: 32];
	end

	assign s_tready = (state_q == ST_IDLE);
	assign accept = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;

	// corner n picks min or max per axis from its bits
	always_comb begin
		case (k_q)
			2'd0: corner_pt = j_q[0] ? hi_q[0] : lo_q[0];
			2'd1: corner_pt = j_q[1] ? hi_q[1] : lo_q[1];
			2'd2: corner_pt = j_q[2] ? hi_q[2] : lo_q[2];
			default: corner_pt = FX_ONE;
		endcase
	end

	// one product per cycle into the shared unit during the matrix and corner phases
	always_comb begin
		req.valid = 1'b0;
		req.first = (k_q == 2'd0);
		req.last = (k_q == 2'd3);
		req.tag = '0;
		req.a = view_q[{r_q, k_q}];
		req.b = model_q[{k_q, j_q[1:0]}];
		case (state_q)
			ST_MV: begin
				req.valid = 1'b1;
				req.tag.idx = {r_q, j_q[1:0]};
			end
			ST_CORNER: begin
				req.valid = 1'b1;
				req.tag.corner = 1'b1;
				req.tag.idx = {2'b00, r_q};
				req.a = mv_q[{r_q, k_q}];
				req.b = corner_pt;
			end
			default: ;
		endcase
	end

	tbb_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q <= '0;
			r_q <= '0;
			j_q <= '0;
			drain_q <= 1'b0;
			m_tvalid_q <= 1'b0;
			for (int i = 0; i < 12; i++)
				view_q[i] <= '0;
			for (int i = 0; i < 16; i++)
				model_q[i] <= '0;
			for (int i = 0; i < 3; i++) begin
				low_q[i] <= WORD_MAX;
				high_q[i] <= WORD_MIN;
			end
		end else begin
			// output register: load a new result, drop it once taken
			if (state_q == ST_OUT && (!m_tvalid_q || m_tready))
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;

			// results from the shared unit
			if (rsp.valid && rsp.tag.corner) begin
				if (rsp.value < low_q[rsp.tag.idx[1:0]])
					low_q[rsp.tag.idx[1:0]] <= rsp.value;
				if (rsp.value > high_q[rsp.tag.idx[1:0]])
					high_q[rsp.tag.idx[1:0]] <= rsp.value;
			end

			case (state_q)
				ST_IDLE: begin
					k_q <= '0;
					r_q <= '0;
					j_q <= '0;
					drain_q <= 1'b0;
					if (accept) begin
						case (op)
							OP_VIEW_ROW: begin
								if (row != 2'd3)
									for (int i = 0; i < 4; i++)
										view_q[{row, 2'(i)}] <= vals[i];
							end
							OP_MODEL_ROW: begin
								for (int i = 0; i < 4; i++)
									model_q[{row, 2'(i)}] <= vals[i];
							end
							OP_BOX: state_q <= ST_MV;
							OP_CLEAR: begin
								for (int i = 0; i < 3; i++) begin
									low_q[i] <= WORD_MAX;
									high_q[i] <= WORD_MIN;
								end
								state_q <= ST_OUT;
							end
							default: ;
						endcase
					end
				end
				ST_MV: begin
					k_q <= k_q + 2'd1;
					if (k_q == 2'd3) begin
						j_q <= {1'b0, j_q[1:0] + 2'd1};
						if (j_q[1:0] == 2'd3) begin
							r_q <= (r_q == 2'd2) ? 2'd0 : r_q + 2'd1;
							if (r_q == 2'd2)
								state_q <= ST_MV_DRAIN;
						end
					end
				end
				ST_MV_DRAIN: begin
					drain_q <= !drain_q;
					if (drain_q)
						state_q <= ST_CORNER;
				end
				ST_CORNER: begin
					k_q <= k_q + 2'd1;
					if (k_q == 2'd3) begin
						r_q <= (r_q == 2'd2) ? 2'd0 : r_q + 2'd1;
						if (r_q == 2'd2) begin
							j_q <= j_q + 3'd1;
							if (j_q == 3'd7)
								state_q <= ST_CN_DRAIN;
						end
					end
				end
				ST_CN_DRAIN: begin
					drain_q <= !drain_q;
					if (drain_q)
						state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!m_tvalid_q || m_tready)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept && op == OP_BOX) begin
			for (int i = 0; i < 3; i++) begin
				lo_q[i] <= vals[i];
				hi_q[i] <= vals[3 + i];
			end
		end
		if (rsp.valid && !rsp.tag.corner)
			mv_q[rsp.tag.idx] <= rsp.value;
		if (state_q == ST_OUT && (!m_tvalid_q || m_tready))
			m_tdata_q <= {high_q[2], high_q[1], high_q[0], low_q[2], low_q[1], low_q[0]};
	end

	a_idle_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !rsp.valid)
		else $error("result from shared unit while idle");

	a_corner_phase: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.tag.corner |-> state_q == ST_CORNER || state_q == ST_CN_DRAIN)
		else $error("corner result outside corner phase");

	a_corner_axis: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.tag.corner |-> rsp.tag.idx < 4'd3)
		else $error("corner result axis out of range");

endmodule

@@ sim/tbb_checker.sv @@
`timescale 1ns / 1ps

module tbb_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [199:0] s_tdata,
	input  logic [1:0]   s_tuser,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [191:0] m_tdata,
	output int           fail_count,
	output int           pending,
	output int           bounds_seen
);
	import tbb_pkg::*;

	word_t view_m [12];
	word_t model_m [16];
	word_t lo_b [3];
	word_t hi_b [3];
	logic [191:0] bounds_q [$];

	function automatic longint fx_product(word_t a, word_t b);
		longint p;
		p = longint'(a) * longint'(b) + (64'sd1 <<< (FRAC_BITS - 1));
		return p >>> FRAC_BITS;
	endfunction

	function automatic word_t clamp32(longint v);
		if (v > longint'(WORD_MAX)) begin
			return WORD_MAX;
		end
		if (v < longint'(WORD_MIN)) begin
			return WORD_MIN;
		end
		return word_t'(v);
	endfunction

	function automatic logic [191:0] pack_bounds();
		return {hi_b[2], hi_b[1], hi_b[0], lo_b[2], lo_b[1], lo_b[0]};
	endfunction

	task automatic widen_box(word_t v [6]);
		word_t mv [12];
		word_t pt [3];
		word_t q;
		longint s;
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 4; c++) begin
				s = 0;
				for (int k = 0; k < 4; k++) begin
					s += fx_product(view_m[r*4+k], model_m[k*4+c]);
				end
				mv[r*4+c] = clamp32(s);
			end
		end
		for (int n = 0; n < 8; n++) begin
			pt[0] = n[0] ? v[3] : v[0];
			pt[1] = n[1] ? v[4] : v[1];
			pt[2] = n[2] ? v[5] : v[2];
			for (int r = 0; r < 3; r++) begin
				s = longint'(mv[r*4+3]);
				for (int k = 0; k < 3; k++) begin
					s += fx_product(mv[r*4+k], pt[k]);
				end
				q = clamp32(s);
				if (q < lo_b[r]) begin
					lo_b[r] = q;
				end
				if (q > hi_b[r]) begin
					hi_b[r] = q;
				end
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (view_m[i]) view_m[i] = '0;
			foreach (model_m[i]) model_m[i] = '0;
			for (int i = 0; i < 3; i++) begin
				lo_b[i] = WORD_MAX;
				hi_b[i] = WORD_MIN;
			end
			bounds_q.delete();
			fail_count = 0;
			bounds_seen = 0;
			pending = 0;
		end else begin
			// output side first: a result never comes out in the cycle its command goes in
			if (m_tvalid && m_tready) begin
				bounds_seen++;
				if (bounds_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10) begin
						$display("unexpected bounds transfer %h", m_tdata);
					end
				end else begin
					logic [191:0] exp_b;
					exp_b = bounds_q.pop_front();
					for (int f = 0; f < 6; f++) begin
						if (exp_b[f*32 +: 32] !== m_tdata[f*32 +: 32]) begin
							fail_count++;
							if (fail_count <= 10) begin
								$display("bounds field %0d: expected %h, got %h", f,
									exp_b[f*32 +: 32], m_tdata[f*32 +: 32]);
							end
						end
					end
				end
			end
			if (s_tvalid && s_tready) begin
				word_t v [6];
				logic [1:0] row;
				row = s_tdata[1:0];
				for (int i = 0; i < 6; i++) begin
					v[i] = s_tdata[2 + i*32 +: 32];
				end
				case (opcode_t'(s_tuser))
					OP_VIEW_ROW: begin
						if (row != 2'd3) begin
							for (int i = 0; i < 4; i++) view_m[row*4+i] = v[i];
						end
					end
					OP_MODEL_ROW: begin
						for (int i = 0; i < 4; i++) model_m[row*4+i] = v[i];
					end
					OP_BOX: begin
						widen_box(v);
						bounds_q = {bounds_q, pack_bounds()};
					end
					default: begin
						for (int i = 0; i < 3; i++) begin
							lo_b[i] = WORD_MAX;
							hi_b[i] = WORD_MIN;
						end
						bounds_q = {bounds_q, pack_bounds()};
					end
				endcase
			end
			pending = bounds_q.size();
		end
	end

endmodule

@@ sim/transformed_box_bounds_tb.sv @@
`timescale 1ns / 1ps

module transformed_box_bounds_tb;
	import tbb_pkg::*;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	// row_index[1:0], val_a, val_b, val_c, val_d, val_e, val_f, zero pad
	logic [199:0] s_tdata;
	// opcode[1:0]
	logic [1:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	// bound_min_x, bound_min_y, bound_min_z, bound_max_x, bound_max_y, bound_max_z
	logic [191:0] m_tdata;

	int fail_count;
	int pending;
	int bounds_seen;
	int cmd_count;
	int box_count;

	transformed_box_bounds uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	tbb_checker bounds_check (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.fail_count(fail_count), .pending(pending), .bounds_seen(bounds_seen)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// receiver stall pattern: each draw sets ready high (60%), random (30%) or low (10%)
	initial begin
		int mode;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			mode = $urandom_range(0, 99);
			if (mode < 60) begin
				m_tready <= 1'b1;
			end else if (mode < 90) begin
				m_tready <= $urandom_range(0, 1);
			end else begin
				m_tready <= 1'b0;
			end
		end
	end

	// generous fixed limit: at least 870 commands, most of them boxes, plus stalls and gaps
	initial begin
		#20ms;
		$display("status: fail");
		$finish;
	end

	// mixes full range values with moderate ones so saturation is present
	function automatic word_t pick_value(bit extreme_ok);
		int k;
		k = $urandom_range(0, 9);
		if (extreme_ok && k == 0) return WORD_MAX;
		if (extreme_ok && k == 1) return WORD_MIN;
		if (k < 4) return word_t'($urandom);
		if (k < 7) return word_t'($signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000);
		return word_t'($signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000);
	endfunction

	// one transfer, held until accepted
	task automatic send_cmd(opcode_t op, logic [1:0] row, word_t v [6]);
		s_tuser <= op;
		s_tdata <= {6'b0, v[5], v[4], v[3], v[2], v[1], v[0], row};
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		cmd_count++;
		if (op == OP_BOX) box_count++;
	endtask

	task automatic idle_gap();
		int g;
		g = $urandom_range(0, 3) == 0 ? $urandom_range(1, 12) : 0;
		if (g != 0) begin
			s_tvalid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	initial begin
		word_t v [6];
		int burst;
		int sel;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = OP_VIEW_ROW;
		cmd_count = 0;
		box_count = 0;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty bounds, view row three ignored, identity matrices,
		// saturating entries, inverted box, extremes in unused fields
		foreach (v[i]) v[i] = 0;
		send_cmd(OP_BOX, 2'd3, v);
		send_cmd(OP_CLEAR, 2'd1, v);
		for (int r = 0; r < 4; r++) begin
			foreach (v[i]) v[i] = (i == r) ? FX_ONE : 0;
			v[4] = WORD_MAX;
			v[5] = WORD_MIN;
			send_cmd(OP_MODEL_ROW, r[1:0], v);
			if (r < 3) send_cmd(OP_VIEW_ROW, r[1:0], v);
		end
		foreach (v[i]) v[i] = WORD_MAX;
		send_cmd(OP_VIEW_ROW, 2'd3, v);
		v = '{32'sh0001_0000, -32'sh0002_0000, 32'sh0003_0000, 32'sh0004_0000, 32'sh0, 32'sh0005_0000};
		send_cmd(OP_BOX, 2'd0, v);
		v = '{32'sh0004_0000, 32'sh0003_0000, 32'sh0002_0000, -32'sh0004_0000, -32'sh0003_0000, 32'sh0};
		send_cmd(OP_BOX, 2'd2, v);
		v = '{WORD_MIN, WORD_MIN, WORD_MIN, WORD_MAX, WORD_MAX, WORD_MAX};
		send_cmd(OP_BOX, 2'd1, v);
		v = '{WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN};
		send_cmd(OP_MODEL_ROW, 2'd0, v);
		send_cmd(OP_VIEW_ROW, 2'd1, v);
		send_cmd(OP_BOX, 2'd3, v);
		send_cmd(OP_CLEAR, 2'd0, v);
		foreach (v[i]) v[i] = '1;
		send_cmd(OP_BOX, 2'd0, v);

		// random: mostly box commands over matrices that change now and then
		while (cmd_count < 870) begin
			burst = $urandom_range(1, 20);
			for (int b = 0; b < burst; b++) begin
				sel = $urandom_range(0, 99);
				foreach (v[i]) v[i] = pick_value(1'b1);
				if (sel < 12) begin
					send_cmd(OP_VIEW_ROW, 2'($urandom_range(0, 3)), v);
				end else if (sel < 26) begin
					send_cmd(OP_MODEL_ROW, 2'($urandom_range(0, 3)), v);
				end else if (sel < 93) begin
					send_cmd(OP_BOX, 2'($urandom_range(0, 3)), v);
				end else begin
					send_cmd(OP_CLEAR, 2'($urandom_range(0, 3)), v);
				end
			end
			idle_gap();
		end
		s_tvalid <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (300) @(posedge clk);

		$display("ran %0d commands, %0d box accumulates, %0d bound results checked",
			cmd_count, box_count, bounds_seen);
		if (fail_count == 0 && pending == 0) begin
			$display("status: pass");
		end else begin
			$display("mismatches: %0d, outstanding: %0d", fail_count, pending);
			$display("status: fail");
		end
		$finish;
	end

endmodule

@@ files.f @@
rtl/tbb_pkg.sv
rtl/tbb_mac.sv
rtl/transformed_box_bounds.sv
sim/tbb_checker.sv
sim/transformed_box_bounds_tb.sv
